@@ hdl/rcpcn_pkg.sv @@
// Shared types and constants of the RC pulse capture and normalize block.
// Used by the scaling unit and the top level.
// No dependencies.
package rcpcn_pkg;

    // Field widths of the calibration and result paths.
    localparam int FIELD_W    = 11;
    localparam int WIDTH_W    = 16;
    localparam int PROD_W     = 20;
    localparam int QUOT_W     = 9;
    localparam int CHAN_W     = 3;
    localparam int CAL_W      = 33;
    localparam int MASK_W     = 6;
    localparam int NUM_CAL    = 6;

    // Configuration port geometry: 64-bit registers at byte address 8*i.
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    // Register index of the reverse mask; indexes below it are calibrations.
    localparam logic [2:0] REG_REVERSE = 3'd6;

    // Scaling constants.
    localparam logic [FIELD_W-1:0] SCALE_MID  = 11'd1500;
    localparam logic [QUOT_W-1:0]  SCALE_SPAN = 9'd500;
    localparam logic [FIELD_W-1:0] SCALE_MIN  = 11'd1000;
    localparam logic [FIELD_W-1:0] SCALE_MAX  = 11'd2000;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX  = 16'hFFFF;

    // Reset values of the configuration registers.
    localparam logic [CAL_W-1:0] CAL_RESET [NUM_CAL] = '{
        33'd8408482801, 33'd8454648830, 33'd8513397772,
        33'd8572146714, 33'd8391789583, 33'd8458834948
    };
    localparam logic [MASK_W-1:0] MASK_RESET = 6'd2;

    // One calibration register: high in the top field, low in the bottom one.
    typedef struct packed {
        logic [FIELD_W-1:0] high;
        logic [FIELD_W-1:0] center;
        logic [FIELD_W-1:0] low;
    } t_cal;

    // Request handed from the channel sequencer to the scaling unit.
    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        t_cal               cal;
        logic               rev;
    } t_scale_req;

endpackage

@@ hdl/rc_pulse_capture_normalize_top.sv @@
// RC pulse capture and normalize: one item in, one result out per pulse end.
// Each item is scanned channel by channel; each pulse end is scaled and pushed before the scan goes on.
// A new item is taken only once the scan of the last one is through; output stalls hold the scan.
// Synchronous active-low reset clears edge state and restores register defaults.
// Depends on rcpcn_pkg and rcpcn_scale.
module rc_pulse_capture_normalize_top
    import rcpcn_pkg::*;
#(
    parameter int NUM_CHANNELS = 6,
    parameter int TIME_BITS    = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Sample channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [5:0]            i_pin_levels,
    input  logic [31:0]           i_time_us,
    // Result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CHAN_W-1:0]     o_channel,
    output logic [WIDTH_W-1:0]    o_pulse_width,
    output logic [FIELD_W-1:0]    o_scaled_value,
    output logic                  o_last_in_run,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CHAN_LIMIT = (NUM_CHANNELS < NUM_CAL) ? NUM_CHANNELS : NUM_CAL;
    localparam int IDX_W      = (CHAN_LIMIT > 1) ? $clog2(CHAN_LIMIT) : 1;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WAIT, S_PUSH} t_state;

    // Configuration registers.
    logic [CAL_W-1:0]      r_cal [NUM_CAL];
    logic [MASK_W-1:0]     r_mask;

    // Per-channel edge state.
    logic [CHAN_LIMIT-1:0] r_prev;
    logic [TIME_BITS-1:0]  r_rise [CHAN_LIMIT];

    // Current item and sequencer.
    t_state                r_state;
    logic [CHAN_LIMIT-1:0] r_levels;
    logic [CHAN_LIMIT-1:0] r_fall;
    logic [TIME_BITS-1:0]  r_now;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_last;
    logic [WIDTH_W-1:0]    r_width;
    logic [FIELD_W-1:0]    r_scaled;
    t_scale_req            r_req;
    logic                  r_scale_start;

    // Output register.
    logic                  r_out_valid;
    logic [CHAN_W-1:0]     r_out_channel;
    logic [WIDTH_W-1:0]    r_out_width;
    logic [FIELD_W-1:0]    r_out_scaled;
    logic                  r_out_last;

    logic [2:0]            w_cfg_idx;
    logic                  w_cfg_wr;
    logic [TIME_BITS-1:0]  w_span;
    logic [WIDTH_W-1:0]    w_width;
    logic [CHAN_LIMIT-1:0] w_bit;
    logic                  w_end_idx;
    logic                  w_scale_done;
    logic [FIELD_W-1:0]    w_scaled;

    // Configuration writes and reads.
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[5:3];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CAL; i++) begin
                r_cal[i] <= CAL_RESET[i];
            end
            r_mask <= MASK_RESET;
        end else if (w_cfg_wr) begin
            if (w_cfg_idx < 3'(NUM_CAL)) begin
                r_cal[w_cfg_idx] <= pwdata[CAL_W-1:0];
            end else if (w_cfg_idx == REG_REVERSE) begin
                r_mask <= pwdata[MASK_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (w_cfg_idx < 3'(NUM_CAL)) begin
            prdata = CFG_DATA_W'(r_cal[w_cfg_idx]);
        end else if (w_cfg_idx == REG_REVERSE) begin
            prdata = CFG_DATA_W'(r_mask);
        end
    end

    // Width of the pulse on the channel being scanned, saturated to 16 bits.
    assign w_span    = r_now - r_rise[r_idx];
    assign w_width   = (w_span > TIME_BITS'(WIDTH_MAX)) ? WIDTH_MAX : w_span[WIDTH_W-1:0];
    assign w_bit     = CHAN_LIMIT'(1) << r_idx;
    assign w_end_idx = (r_idx == IDX_W'(CHAN_LIMIT - 1));

    rcpcn_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_scale_start),
        .i_req    (r_req),
        .o_done   (w_scale_done),
        .o_scaled (w_scaled)
    );

    // Channel sequencer: scan one channel a cycle, stop to scale each pulse end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_prev        <= '0;
            r_scale_start <= 1'b0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < CHAN_LIMIT; i++) begin
                r_rise[i] <= '0;
            end
        end else begin
            // A push in the same cycle refills the output register instead.
            if (r_out_valid && i_out_ready && (r_state != S_PUSH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_levels <= i_pin_levels[CHAN_LIMIT-1:0];
                        r_fall   <= ~i_pin_levels[CHAN_LIMIT-1:0] & r_prev;
                        r_now    <= TIME_BITS'(i_time_us);
                        r_idx    <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_levels[r_idx] && !r_prev[r_idx]) begin
                        r_prev[r_idx] <= 1'b1;
                        r_rise[r_idx] <= r_now;
                    end
                    if (!r_levels[r_idx] && r_prev[r_idx]) begin
                        r_prev[r_idx]  <= 1'b0;
                        r_fall         <= r_fall & ~w_bit;
                        r_last         <= ((r_fall & ~w_bit) == '0);
                        r_width        <= w_width;
                        r_req.width    <= w_width;
                        r_req.cal      <= t_cal'(r_cal[3'(r_idx)]);
                        r_req.rev      <= r_mask[3'(r_idx)];
                        r_scale_start  <= 1'b1;
                        r_state        <= S_WAIT;
                    end else if (w_end_idx) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_WAIT: begin
                    r_scale_start <= 1'b0;
                    if (w_scale_done) begin
                        r_scaled <= w_scaled;
                        r_state  <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_channel <= CHAN_W'(r_idx);
                        r_out_width   <= r_width;
                        r_out_scaled  <= r_scaled;
                        r_out_last    <= r_last;
                        if (w_end_idx) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_channel      = r_out_channel;
    assign o_pulse_width  = r_out_width;
    assign o_scaled_value = r_out_scaled;
    assign o_last_in_run  = r_out_last;

    // An accepted item keeps the block busy for at least its scan.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("block ready again right after taking an item");

    // The scaling unit only reports back while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scale_done |-> (r_state == S_WAIT))
        else $error("scale result arrived outside the wait state");

    // Edge state changes only during a channel scan.
    a_prev_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SCAN) |=> $stable(r_prev))
        else $error("edge state changed outside a scan");

    // A delivered value lies in the normalized range.
    a_scaled_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_scaled_value >= SCALE_MIN && o_scaled_value <= SCALE_MAX))
        else $error("scaled value out of range");

    // A result names one of the processed channels.
    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_channel < CHAN_W'(CHAN_LIMIT)))
        else $error("result channel out of range");

endmodule

@@ hdl/rcpcn_serdiv.sv @@
// Restoring divider that produces one quotient bit per cycle.
// Depends on nothing; parameters set the dividend and divisor widths.
module rcpcn_serdiv #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;

    logic [DEN_W:0]   w_rem_sh;
    logic [DEN_W:0]   w_den_ext;
    logic [DEN_W:0]   w_sub;
    logic             w_ge;

    // Bring down the next dividend bit and trial-subtract the divisor.
    assign w_rem_sh  = {r_rem, r_quo[NUM_W-1]};
    assign w_den_ext = {1'b0, r_den};
    assign w_sub     = w_rem_sh - w_den_ext;
    assign w_ge      = (w_rem_sh >= w_den_ext);

    // The dividend shifts out of the quotient register as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_run && !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_quo <= i_num;
                r_rem <= '0;
                r_den <= i_den;
                r_cnt <= CNT_W'(NUM_W);
                r_run <= 1'b1;
            end else if (r_run) begin
                r_quo <= {r_quo[NUM_W-2:0], w_ge};
                r_rem <= w_ge ? w_sub[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

@@ hdl/rcpcn_scale.sv @@
// Clamps a pulse width to its calibration and scales it to 1000..2000.
// Depends on rcpcn_pkg and the serial divider rcpcn_serdiv.
module rcpcn_scale
    import rcpcn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_scale_req         i_req,
    output logic               o_done,
    output logic [FIELD_W-1:0] o_scaled
);

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV, S_DONE} t_state;

    t_state              r_state;
    logic [FIELD_W-1:0]  r_num;
    logic [FIELD_W-1:0]  r_den;
    logic [QUOT_W-1:0]   r_diff;
    logic                r_neg;

    logic [WIDTH_W-1:0]  w_lo;
    logic [WIDTH_W-1:0]  w_ce;
    logic [WIDTH_W-1:0]  w_hi;
    logic                w_below;
    logic                w_above;
    logic [FIELD_W-1:0]  w_act_lo;
    logic [FIELD_W-1:0]  w_act_hi;
    logic [PROD_W-1:0]   w_prod;
    logic                w_div_done;
    logic [PROD_W-1:0]   w_quot;

    // Compare the width against the calibration points at full width.
    assign w_lo     = WIDTH_W'(i_req.cal.low);
    assign w_ce     = WIDTH_W'(i_req.cal.center);
    assign w_hi     = WIDTH_W'(i_req.cal.high);
    assign w_below  = (i_req.width < w_ce);
    assign w_above  = (i_req.width > w_ce);
    assign w_act_lo = (i_req.width < w_lo) ? i_req.cal.low  : i_req.width[FIELD_W-1:0];
    assign w_act_hi = (i_req.width > w_hi) ? i_req.cal.high : i_req.width[FIELD_W-1:0];

    // The distance from center times the span feeds the divider's load register.
    assign w_prod = PROD_W'(r_num) * PROD_W'(SCALE_SPAN);

    rcpcn_serdiv #(
        .NUM_W (PROD_W),
        .DEN_W (FIELD_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LOAD),
        .i_num   (w_prod),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Sequencer: sort out the special cases, otherwise run one division.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_neg <= w_below ^ i_req.rev;
                        if (w_below) begin
                            if (i_req.cal.low == i_req.cal.center) begin
                                r_diff  <= '0;
                                r_state <= S_DONE;
                            end else if (i_req.cal.low > i_req.cal.center) begin
                                r_diff  <= SCALE_SPAN;
                                r_state <= S_DONE;
                            end else begin
                                r_num   <= i_req.cal.center - w_act_lo;
                                r_den   <= i_req.cal.center - i_req.cal.low;
                                r_state <= S_LOAD;
                            end
                        end else if (w_above) begin
                            if (i_req.cal.high == i_req.cal.center) begin
                                r_diff  <= '0;
                                r_state <= S_DONE;
                            end else if (i_req.cal.high < i_req.cal.center) begin
                                r_diff  <= SCALE_SPAN;
                                r_state <= S_DONE;
                            end else begin
                                r_num   <= w_act_hi - i_req.cal.center;
                                r_den   <= i_req.cal.high - i_req.cal.center;
                                r_state <= S_LOAD;
                            end
                        end else begin
                            r_diff  <= '0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_diff  <= w_quot[QUOT_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The quotient never exceeds the span, so the result stays in 1000..2000.
    assign o_done   = (r_state == S_DONE);
    assign o_scaled = r_neg ? (SCALE_MID - FIELD_W'(r_diff)) : (SCALE_MID + FIELD_W'(r_diff));

endmodule
